/* rtl/cvsd_pkg.sv */
// shared types, register indexes and constants of the cvsd decoder
package cvsd_pkg;

  // field widths
  localparam int unsigned IncW    = 10;
  localparam int unsigned DecayW  = 15;
  localparam int unsigned GainW   = 16;
  localparam int unsigned StepW   = 19;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // shared multiplier operand and product widths
  localparam int unsigned MulAW = 17;
  localparam int unsigned MulBW = 20;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned FracW = 15;
  localparam int unsigned TermW = ProdW - FracW;
  localparam int unsigned AccW  = TermW + 1;
  localparam int unsigned SumW  = TermW + 2;

  // step ceiling and sample limits
  localparam logic [StepW-1:0] StepMax = {StepW{1'b1}};
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = -16'sh8000;

  // register reset values
  localparam logic [IncW-1:0]   SmallIncRst  = 10'd3;
  localparam logic [IncW-1:0]   LargeIncRst  = 10'd255;
  localparam logic [DecayW-1:0] StepDecayRst = 15'd32260;
  localparam logic [GainW-1:0]  Tap1GainRst  = 16'd41641;
  localparam logic [GainW-1:0]  Tap2GainRst  = 16'd10492;
  localparam logic [GainW-1:0]  StepGainRst  = 16'd49453;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SMALL_INC  = 3'd0,
    REG_LARGE_INC  = 3'd1,
    REG_STEP_DECAY = 3'd2,
    REG_TAP1_GAIN  = 3'd3,
    REG_TAP2_GAIN  = 3'd4,
    REG_STEP_GAIN  = 3'd5
  } cfg_idx_t;

  // configuration register contents
  typedef struct packed {
    logic [IncW-1:0]   small_increment;
    logic [IncW-1:0]   large_increment;
    logic [DecayW-1:0] step_decay;
    logic [GainW-1:0]  first_tap_gain;
    logic [GainW-1:0]  second_tap_gain;
    logic [GainW-1:0]  step_gain;
  } cfg_t;

  // input beat
  typedef struct packed {
    logic code_bit;
    logic frame_end;
  } bit_beat_t;

  // output beat
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_sample;
  } pcm_beat_t;

endpackage

/* rtl/cvsd_decoder.sv */
// CVSD decoder top level: sequencer, step adaptation and reconstruction filter
//
// Takes one code bit per beat and returns one saturated 16-bit PCM sample per
// beat. One 17x20 signed multiplier is shared for the four products of a bit
// (step decay, first tap, second tap, step gain), issued in turn by a small
// sequencer through its states UPD, Y1, Y2 and SUM, so a new bit is taken
// only once the sample of the last one has entered the output register:
// bit_stall is high during reset and while the sequencer is busy with a bit,
// and longer if the previous sample is still held in the output register.
// Configuration is written through a plain write port with indexes 0 to 5;
// writes to other indexes are dropped.
module cvsd_decoder
  import cvsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               bit_valid,
  output logic               bit_stall,
  input  bit_beat_t          bit_data,
  output logic               pcm_valid,
  input  logic               pcm_stall,
  output pcm_beat_t          pcm_data,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_UPD  = 5'b00010,
    ST_Y1   = 5'b00100,
    ST_Y2   = 5'b01000,
    ST_SUM  = 5'b10000
  } state_t;

  state_t state, state_next;
  cfg_t   cfg;

  logic                      cur_bit;
  logic                      cur_last;
  logic [1:0]                hist_valid;
  logic [1:0]                hist_bit;
  logic [StepW-1:0]          step_size;
  logic signed [SampleW-1:0] y1, y2;
  logic signed [AccW-1:0]    acc;

  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [ProdW-1:0]   prod;

  logic                      accept;
  logic                      out_free;
  logic                      agree;
  logic [StepW:0]            step_sum;
  logic [StepW-1:0]          step_new;
  logic signed [TermW-1:0]   term;
  logic signed [SumW-1:0]    total;
  logic signed [SampleW-1:0] sample_sat;

  cvsd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cvsd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // handshake
  assign accept    = bit_valid && !bit_stall;
  assign bit_stall = rst || (state != ST_IDLE);
  assign out_free  = !pcm_valid || !pcm_stall;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = {{(MulAW-DecayW){1'b0}}, cfg.step_decay};
    mul_b = {{(MulBW-StepW){1'b0}}, step_size};
    unique case (state)
      ST_IDLE: begin
        mul_a = {{(MulAW-DecayW){1'b0}}, cfg.step_decay};
        mul_b = {{(MulBW-StepW){1'b0}}, step_size};
      end
      ST_UPD: begin
        mul_a = {{(MulAW-GainW){1'b0}}, cfg.first_tap_gain};
        mul_b = MulBW'(y1);
      end
      ST_Y1: begin
        mul_a = {{(MulAW-GainW){1'b0}}, cfg.second_tap_gain};
        mul_b = MulBW'(y2);
      end
      ST_Y2, ST_SUM: begin
        mul_a = {{(MulAW-GainW){1'b0}}, cfg.step_gain};
        mul_b = {{(MulBW-StepW){1'b0}}, step_size};
      end
      default: ;
    endcase
  end

  // step adaptation: decayed step plus small or large increment, saturated
  assign agree    = hist_valid[0] && hist_valid[1] &&
                    (hist_bit[0] == cur_bit) && (hist_bit[1] == cur_bit);
  assign step_sum = {1'b0, prod[FracW+StepW-1:FracW]} +
                    (StepW+1)'(agree ? cfg.large_increment : cfg.small_increment);
  assign step_new = step_sum[StepW] ? StepMax : step_sum[StepW-1:0];

  // floor shift of the product and final sum with saturation
  assign term  = prod[ProdW-1:FracW];
  assign total = cur_bit ? (SumW'(acc) + SumW'(term)) : (SumW'(acc) - SumW'(term));

  always_comb begin
    if (total >= SumW'(SampleMax)) begin
      sample_sat = SampleMax;
    end else if (total <= SumW'(SampleMin)) begin
      sample_sat = SampleMin;
    end else begin
      sample_sat = total[SampleW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_UPD;
      ST_UPD:  state_next = ST_Y1;
      ST_Y1:   state_next = ST_Y2;
      ST_Y2:   state_next = ST_SUM;
      ST_SUM:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // captured input beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_bit  <= bit_data.code_bit;
      cur_last <= bit_data.frame_end;
    end
  end

  // filter accumulator
  always_ff @(posedge clk) begin
    if (state == ST_Y1) begin
      acc <= AccW'(term);
    end else if (state == ST_Y2) begin
      acc <= acc - AccW'(term);
    end
  end

  // decoder state: step size, bit and sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= '0;
      hist_valid <= '0;
      hist_bit   <= '0;
      y1         <= '0;
      y2         <= '0;
    end else begin
      if (state == ST_UPD) begin
        step_size <= step_new;
      end
      if (state == ST_SUM && out_free) begin
        hist_valid <= {hist_valid[0], 1'b1};
        hist_bit   <= {hist_bit[0], cur_bit};
        y2         <= y1;
        y1         <= sample_sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pcm_valid <= 1'b0;
    end else if (state == ST_SUM && out_free) begin
      pcm_valid <= 1'b1;
    end else if (!pcm_stall) begin
      pcm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM && out_free) begin
      pcm_data.sample      <= sample_sat;
      pcm_data.last_sample <= cur_last;
    end
  end

endmodule

/* rtl/cvsd_regs.sv */
// configuration register file of the cvsd decoder
module cvsd_regs
  import cvsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output cfg_t               cfg
);

  // indexed writes, masked to each register width, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.small_increment <= SmallIncRst;
      cfg.large_increment <= LargeIncRst;
      cfg.step_decay      <= StepDecayRst;
      cfg.first_tap_gain  <= Tap1GainRst;
      cfg.second_tap_gain <= Tap2GainRst;
      cfg.step_gain       <= StepGainRst;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SMALL_INC:  cfg.small_increment <= cfg_data[IncW-1:0];
        REG_LARGE_INC:  cfg.large_increment <= cfg_data[IncW-1:0];
        REG_STEP_DECAY: cfg.step_decay      <= cfg_data[DecayW-1:0];
        REG_TAP1_GAIN:  cfg.first_tap_gain  <= cfg_data[GainW-1:0];
        REG_TAP2_GAIN:  cfg.second_tap_gain <= cfg_data[GainW-1:0];
        REG_STEP_GAIN:  cfg.step_gain       <= cfg_data[GainW-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/cvsd_mul.sv */
// shared signed multiplier with registered product
module cvsd_mul
  import cvsd_pkg::*;
(
  input  logic                    clk,
  input  logic signed [MulAW-1:0] a,
  input  logic signed [MulBW-1:0] b,
  output logic signed [ProdW-1:0] prod
);

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    prod <= ProdW'(a) * ProdW'(b);
  end

endmodule

/* tb/sv/cvsd_checker.sv */
// checker for the cvsd decoder: watches both beat channels and the register port
module cvsd_checker
  import cvsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               bit_valid,
  input  logic               bit_stall,
  input  bit_beat_t          bit_data,
  input  logic               pcm_valid,
  input  logic               pcm_stall,
  input  pcm_beat_t          pcm_data,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow registers and decoder state
  cfg_t                      cfg_copy;
  logic [StepW-1:0]          step_acc;
  int                        sign_hist [2];
  logic signed [SampleW-1:0] pcm_hist [2];
  pcm_beat_t                 samples_due [$];

  // one code bit in, one pcm sample out; advances the shadow state
  function automatic pcm_beat_t decode_bit(bit_beat_t b);
    int                        sgn;
    int                        agree;
    longint                    next_step;
    longint                    tap1_term;
    longint                    tap2_term;
    longint                    step_term;
    longint                    total;
    pcm_beat_t                 r;
    sgn = b.code_bit ? 1 : -1;
    agree = sgn + sign_hist[0] + sign_hist[1];

    // syllabic step adaptation
    next_step = (longint'(cfg_copy.step_decay) * longint'(step_acc)) >>> FracW;
    if (agree == 3 || agree == -3) begin
      next_step += longint'(cfg_copy.large_increment);
    end else begin
      next_step += longint'(cfg_copy.small_increment);
    end
    if (next_step > longint'(StepMax)) begin
      next_step = longint'(StepMax);
    end
    step_acc = next_step[StepW-1:0];

    // two-tap reconstruction, floor shifts
    tap1_term = (longint'(cfg_copy.first_tap_gain) * longint'(pcm_hist[0])) >>> FracW;
    tap2_term = (longint'(cfg_copy.second_tap_gain) * longint'(pcm_hist[1])) >>> FracW;
    step_term = (longint'(cfg_copy.step_gain) * longint'(step_acc)) >>> FracW;
    if (sgn < 0) begin
      step_term = -step_term;
    end
    total = tap1_term - tap2_term + step_term;

    // clamp to 16 bits
    if (total >= longint'(SampleMax)) begin
      r.sample = SampleMax;
    end else if (total <= longint'(SampleMin)) begin
      r.sample = SampleMin;
    end else begin
      r.sample = total[SampleW-1:0];
    end
    r.last_sample = b.frame_end;

    sign_hist[1] = sign_hist[0];
    sign_hist[0] = sgn;
    pcm_hist[1] = pcm_hist[0];
    pcm_hist[0] = r.sample;
    return r;
  endfunction

  always @(posedge clk) begin
    pcm_beat_t want;
    if (rst) begin
      cfg_copy.small_increment = SmallIncRst;
      cfg_copy.large_increment = LargeIncRst;
      cfg_copy.step_decay      = StepDecayRst;
      cfg_copy.first_tap_gain  = Tap1GainRst;
      cfg_copy.second_tap_gain = Tap2GainRst;
      cfg_copy.step_gain       = StepGainRst;
      step_acc = '0;
      sign_hist[0] = 0;
      sign_hist[1] = 0;
      pcm_hist[0] = '0;
      pcm_hist[1] = '0;
      samples_due.delete();
      errors = 0;
    end else begin
      // register writes, masked to width; unknown indexes dropped
      if (cfg_write) begin
        case (cfg_index)
          REG_SMALL_INC:  cfg_copy.small_increment = cfg_data[IncW-1:0];
          REG_LARGE_INC:  cfg_copy.large_increment = cfg_data[IncW-1:0];
          REG_STEP_DECAY: cfg_copy.step_decay      = cfg_data[DecayW-1:0];
          REG_TAP1_GAIN:  cfg_copy.first_tap_gain  = cfg_data[GainW-1:0];
          REG_TAP2_GAIN:  cfg_copy.second_tap_gain = cfg_data[GainW-1:0];
          REG_STEP_GAIN:  cfg_copy.step_gain       = cfg_data[GainW-1:0];
          default: ;
        endcase
      end

      // code bit beat accepted
      if (bit_valid && !bit_stall) begin
        samples_due.push_back(decode_bit(bit_data));
      end

      // pcm beat accepted
      if (pcm_valid && !pcm_stall) begin
        if (samples_due.size() == 0) begin
          errors++;
          $error("pcm beat with no sample expected: sample %0d last_sample %0b",
                 pcm_data.sample, pcm_data.last_sample);
        end else begin
          want = samples_due.pop_front();
          if (pcm_data.sample !== want.sample) begin
            errors++;
            $error("sample mismatch: expected %0d, actual %0d", want.sample, pcm_data.sample);
          end
          if (pcm_data.last_sample !== want.last_sample) begin
            errors++;
            $error("last_sample mismatch: expected %0b, actual %0b",
                   want.last_sample, pcm_data.last_sample);
          end
        end
      end
    end
    pending = samples_due.size();
  end

endmodule

/* tb/sv/testbench.sv */
// top of the cvsd decoder testbench: clock, reset, stimulus and verdict
module testbench;
  import cvsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 3000;
  localparam int DirCount      = 24;
  // indexes past the register list, writes there must be dropped
  localparam logic [CfgIdxW-1:0] SpareIdxA = 3'd6;
  localparam logic [CfgIdxW-1:0] SpareIdxB = 3'd7;
  // start of stream, runs of agreement both ways, and alternation
  localparam logic [DirCount-1:0] DirBits = 24'b111100010101100111110000;

  logic               clk;
  logic               rst;
  logic               bit_valid;
  logic               bit_stall;
  bit_beat_t          bit_data;
  logic               pcm_valid;
  logic               pcm_stall;
  pcm_beat_t          pcm_data;
  logic               cfg_write;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  int                 errors;
  int                 pending;

  int send_idle;
  int recv_idle;
  bit hold_go;
  int quiet_cycles;

  cvsd_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .bit_valid (bit_valid),
    .bit_stall (bit_stall),
    .bit_data  (bit_data),
    .pcm_valid (pcm_valid),
    .pcm_stall (pcm_stall),
    .pcm_data  (pcm_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cvsd_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .bit_valid (bit_valid),
    .bit_stall (bit_stall),
    .bit_data  (bit_data),
    .pcm_valid (pcm_valid),
    .pcm_stall (pcm_stall),
    .pcm_data  (pcm_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pcm receiver: random stalls plus one long hold-off on request
  initial begin
    bit hold_served;
    hold_served = 1'b0;
    pcm_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_served) begin
        hold_served = 1'b1;
        pcm_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        pcm_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((bit_valid && !bit_stall) || (pcm_valid && !pcm_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one code bit beat, with random idle cycles ahead of it
  task automatic send_bit(input bit_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      bit_valid <= 1'b0;
      bit_data  <= bit_beat_t'(2'($urandom));
      @(negedge clk);
    end
    bit_valid <= 1'b1;
    bit_data  <= b;
    @(posedge clk);
    while (bit_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // random bits; keep_pct sets how often the previous bit repeats
  task automatic send_burst(input int count, input int keep_pct);
    bit_beat_t b;
    logic      prev;
    prev = 1'($urandom_range(1));
    for (int i = 0; i < count; i++) begin
      b.code_bit  = ($urandom_range(99) < keep_pct) ? prev : ~prev;
      b.frame_end = ($urandom_range(7) == 0);
      prev = b.code_bit;
      send_bit(b);
    end
  endtask

  // wait until every sample is back and the block is quiet
  task automatic drain();
    bit_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // write all six registers, plus the two unused indexes
  task automatic program_regs(input logic [CfgW-1:0] small_v, input logic [CfgW-1:0] large_v,
                              input logic [CfgW-1:0] decay_v, input logic [CfgW-1:0] tap1_v,
                              input logic [CfgW-1:0] tap2_v, input logic [CfgW-1:0] gain_v);
    put_reg(REG_SMALL_INC, small_v);
    put_reg(REG_LARGE_INC, large_v);
    put_reg(REG_STEP_DECAY, decay_v);
    put_reg(REG_TAP1_GAIN, tap1_v);
    put_reg(REG_TAP2_GAIN, tap2_v);
    put_reg(REG_STEP_GAIN, gain_v);
    put_reg(SpareIdxA, CfgW'($urandom));
    put_reg(SpareIdxB, CfgW'($urandom));
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    bit_beat_t b;
    rst       = 1'b1;
    bit_valid = 1'b0;
    bit_data  = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_go   = 1'b0;
    send_idle = 25;
    recv_idle = 46;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed bits at reset settings, from the start of the stream
    for (int i = 0; i < DirCount; i++) begin
      b.code_bit  = DirBits[DirCount-1-i];
      b.frame_end = (i % 8 == 7);
      send_bit(b);
    end
    drain();

    // all ones written, upper bits masked off
    program_regs('1, '1, '1, '1, '1, '1);
    send_burst(150, 60);
    drain();

    // sender idles more than the receiver from here
    send_idle = 46;
    recv_idle = 25;

    // all zero settings
    program_regs('0, '0, '0, '0, '0, '0);
    send_burst(50, 50);
    drain();

    // decay at full scale: step runs into its ceiling; long output hold-off
    program_regs(CfgW'(1023), CfgW'(1023), CfgW'(32767), CfgW'($urandom),
                 CfgW'($urandom), CfgW'($urandom));
    hold_go = 1'b1;
    send_burst(600, 50);
    drain();

    // no idling on either side
    send_idle = 0;
    recv_idle = 0;

    // random settings within the register widths, decay fixed at 32640
    program_regs(CfgW'($urandom_range(1023)), CfgW'($urandom_range(1023)), CfgW'(32640),
                 CfgW'($urandom_range(65535)), CfgW'($urandom_range(65535)),
                 CfgW'($urandom_range(65535)));
    send_burst(150, 75);
    drain();

    // random raw register data
    program_regs(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom),
                 CfgW'($urandom), CfgW'($urandom));
    send_burst(150, 35);
    drain();

    // late or extra beats still count
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
